>>> design/mlfp_pkg.sv
// Shared types, codes and constants for the marker/length frame parser.
package mlfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam logic [WordW-1:0] HdrOverhead = 16'd3;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_MARK2   = 4'd1,
    PH_LEN_HI  = 4'd2,
    PH_LEN_LO  = 4'd3,
    PH_OP      = 4'd4,
    PH_ID_HI   = 4'd5,
    PH_ID_LO   = 4'd6,
    PH_DATA    = 4'd7,
    PH_TRAIL1  = 4'd8,
    PH_TRAIL2  = 4'd9
  } mlfp_phase_t;

  typedef enum logic [2:0] {
    K_HEADER     = 3'd0,
    K_PAYLOAD    = 3'd1,
    K_DONE       = 3'd2,
    K_BAD_MARKER = 3'd3,
    K_BAD_LENGTH = 3'd4
  } mlfp_kind_t;

  // configuration register indexes
  localparam logic CfgFirstMarker  = 1'b0;
  localparam logic CfgSecondMarker = 1'b1;

  localparam logic [ByteW-1:0] FirstMarkerReset  = 8'd170;
  localparam logic [ByteW-1:0] SecondMarkerReset = 8'd85;

  typedef struct packed {
    mlfp_kind_t        kind;
    logic [ByteW-1:0]  op_type;
    logic [WordW-1:0]  msg_id;
    logic [WordW-1:0]  payload_length;
    logic [ByteW-1:0]  data_byte;
    logic              last_payload;
  } mlfp_result_t;

endpackage

>>> design/marker_length_frame_parser_core.sv
// Top level of the marker/length frame parser: input register, parser, result queue.
//
// Usage:
//   Bytes of the received stream enter one per request on the input channel
//   (in_valid / in_ready / rx_byte). Each byte lands in an input register and
//   is parsed when the queue has room; the parse step yields zero or one
//   result, which is queued in a two-entry result queue that drives the
//   output channel (out_valid / out_ready and the result fields).
//   Throughput: one byte per cycle, sustained, while out_ready stays high.
//   A result passes through the input register and then a queue entry before
//   it is offered on the output.
//   The parse step fires whenever a byte is held and the queue has a free
//   slot; that slot count (a registered value) is what sets in_ready, so there is no
//   combinational path from out_ready to in_ready.
//   Stall: when the receiver holds out_ready low the queue fills, the parsed
//   byte waits in the input register, and in_ready drops; nothing is lost.
//   Configuration: cfg_we writes cfg_data into the marker register picked by
//   cfg_index (0 first marker, 1 second marker); write only while idle.
//   Reset (rst, synchronous): parser returns to hunting for the first marker,
//   queue and input register empty, markers back to 0xAA and 0x55.
module marker_length_frame_parser_core import mlfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [ByteW-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ByteW-1:0]  rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        kind,
  output logic [ByteW-1:0]  op_type,
  output logic [WordW-1:0]  msg_id,
  output logic [WordW-1:0]  payload_length,
  output logic [ByteW-1:0]  data_byte,
  output logic              last_payload
);

  logic [ByteW-1:0] first_marker, second_marker;
  logic             byte_valid;
  logic [ByteW-1:0] byte_q;
  logic             q_space;
  logic             step;
  logic             res_valid;
  mlfp_result_t     res, out_res;

  // marker registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_marker  <= FirstMarkerReset;
      second_marker <= SecondMarkerReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgFirstMarker:  first_marker  <= cfg_data;
        CfgSecondMarker: second_marker <= cfg_data;
        default: ;
      endcase
    end
  end

  // a held byte is parsed as soon as the queue can take its result
  assign step     = byte_valid & q_space;
  assign in_ready = ~byte_valid | q_space;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_ready) begin
      byte_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) byte_q <= rx_byte;
  end

  mlfp_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .rx_byte       (byte_q),
    .first_marker  (first_marker),
    .second_marker (second_marker),
    .res_valid     (res_valid),
    .res           (res)
  );

  mlfp_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (step & res_valid),
    .push_data (res),
    .space     (q_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign kind           = out_res.kind;
  assign op_type        = out_res.op_type;
  assign msg_id         = out_res.msg_id;
  assign payload_length = out_res.payload_length;
  assign data_byte      = out_res.data_byte;
  assign last_payload   = out_res.last_payload;

  // last mark only ever rides on a payload byte
  a_last_on_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_payload |-> kind == K_PAYLOAD)
    else $error("last_payload set on a non-payload result");

  // error results carry no frame information
  a_error_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == K_BAD_MARKER || kind == K_BAD_LENGTH)
    |-> op_type == '0 && msg_id == '0 && payload_length == '0 && data_byte == '0)
    else $error("error result carries frame fields");

  // with the input register empty the block must take a request
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !byte_valid |-> in_ready)
    else $error("input not ready with empty input register");

  // a held byte that cannot be parsed stays held
  a_byte_held: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !q_space |=> byte_valid && $stable(byte_q))
    else $error("held byte lost while queue full");

endmodule

>>> design/mlfp_parser.sv
// Frame parse state machine: consumes one byte per step, produces zero or one result.
module mlfp_parser import mlfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [ByteW-1:0]  rx_byte,
  input  logic [ByteW-1:0]  first_marker,
  input  logic [ByteW-1:0]  second_marker,
  output logic              res_valid,
  output mlfp_result_t      res
);

  mlfp_phase_t       phase, phase_next;
  logic [WordW-1:0]  bytes_left, bytes_left_next;
  logic [WordW-1:0]  length_field, length_field_next;
  logic [ByteW-1:0]  held_op_type, held_op_type_next;
  logic [WordW-1:0]  held_msg_id, held_msg_id_next;
  logic [WordW-1:0]  len_full;
  logic [WordW-1:0]  bytes_dec;

  assign len_full  = {length_field[WordW-1:ByteW], rx_byte};
  assign bytes_dec = (bytes_left != '0) ? bytes_left - 16'd1 : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HUNT;
      bytes_left   <= '0;
      length_field <= '0;
      held_op_type <= '0;
      held_msg_id  <= '0;
    end else if (step) begin
      phase        <= phase_next;
      bytes_left   <= bytes_left_next;
      length_field <= length_field_next;
      held_op_type <= held_op_type_next;
      held_msg_id  <= held_msg_id_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    length_field_next = length_field;
    held_op_type_next = held_op_type;
    held_msg_id_next  = held_msg_id;
    res_valid         = 1'b0;
    res.kind           = K_BAD_MARKER;
    res.op_type        = '0;
    res.msg_id         = '0;
    res.payload_length = '0;
    res.data_byte      = '0;
    res.last_payload   = 1'b0;

    unique case (phase)
      PH_MARK2: begin
        if (rx_byte == second_marker) begin
          phase_next = PH_LEN_HI;
        end else begin
          phase_next = PH_HUNT;
          res_valid  = 1'b1;
        end
      end
      PH_LEN_HI: begin
        length_field_next = {rx_byte, {ByteW{1'b0}}};
        phase_next        = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_field_next = len_full;
        if (len_full < HdrOverhead) begin
          phase_next = PH_HUNT;
          res_valid  = 1'b1;
          res.kind   = K_BAD_LENGTH;
        end else begin
          bytes_left_next = len_full - HdrOverhead;
          phase_next      = PH_OP;
        end
      end
      PH_OP: begin
        held_op_type_next = rx_byte;
        phase_next        = PH_ID_HI;
      end
      PH_ID_HI: begin
        held_msg_id_next = {rx_byte, {ByteW{1'b0}}};
        phase_next       = PH_ID_LO;
      end
      PH_ID_LO: begin
        held_msg_id_next   = {held_msg_id[WordW-1:ByteW], rx_byte};
        phase_next         = (bytes_left != '0) ? PH_DATA : PH_TRAIL1;
        res_valid          = 1'b1;
        res.kind           = K_HEADER;
        res.op_type        = held_op_type;
        res.msg_id         = {held_msg_id[WordW-1:ByteW], rx_byte};
        res.payload_length = length_field - HdrOverhead;
      end
      PH_DATA: begin
        bytes_left_next    = bytes_dec;
        if (bytes_dec == '0) phase_next = PH_TRAIL1;
        res_valid          = 1'b1;
        res.kind           = K_PAYLOAD;
        res.op_type        = held_op_type;
        res.msg_id         = held_msg_id;
        res.payload_length = length_field - HdrOverhead;
        res.data_byte      = rx_byte;
        res.last_payload   = (bytes_left <= 16'd1);
      end
      PH_TRAIL1: begin
        phase_next = PH_TRAIL2;
      end
      PH_TRAIL2: begin
        phase_next         = PH_HUNT;
        res_valid          = 1'b1;
        res.kind           = K_DONE;
        res.op_type        = held_op_type;
        res.msg_id         = held_msg_id;
        res.payload_length = length_field - HdrOverhead;
      end
      default: begin
        // hunting, and any phase code that means nothing
        if (rx_byte == first_marker) begin
          phase_next = PH_MARK2;
        end else begin
          phase_next = PH_HUNT;
          res_valid  = 1'b1;
        end
      end
    endcase
  end

endmodule

>>> design/mlfp_out_queue.sv
// Two-entry result queue; output side driven straight from registers.
module mlfp_out_queue import mlfp_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mlfp_result_t  push_data,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output mlfp_result_t  out_data
);

  mlfp_result_t entry [2];
  logic         wr_ptr, rd_ptr;
  logic [1:0]   count;
  logic         pop;

  assign space     = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid & out_ready;
  assign out_data  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

>>> bench/marker_length_frame_parser_core_tb.sv
// Testbench for the marker/length frame parser core: directed frames, marker settings, random streams.
module marker_length_frame_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mlfp_pkg::*;

  // Cycles with no request on either channel before the run is abandoned.
  // The worst legal quiet stretch is a long sender gap or receiver stall at
  // 60 percent idling, or a settle pause; this is far beyond any of them.
  localparam int StallLimit  = 1000;
  // Quiet cycles after the last parse result so that a byte still sitting in
  // the input register (one that makes no result) is parsed before a write.
  localparam int DrainCycles = 8;
  localparam int MaxReports  = 10;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic             clk            = 1'b0;
  logic             rst            = 1'b1;
  logic             cfg_we         = 1'b0;
  logic             cfg_index      = CfgFirstMarker;
  logic [ByteW-1:0] cfg_data       = '0;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  logic [ByteW-1:0] rx_byte        = '0;
  logic             out_valid;
  logic             out_ready      = 1'b0;
  logic [2:0]       kind;
  logic [ByteW-1:0] op_type;
  logic [WordW-1:0] msg_id;
  logic [WordW-1:0] payload_length;
  logic [ByteW-1:0] data_byte;
  logic             last_payload;

  initial begin
    forever #5 clk = ~clk;
  end

  marker_length_frame_parser_core i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .op_type        (op_type),
    .msg_id         (msg_id),
    .payload_length (payload_length),
    .data_byte      (data_byte),
    .last_payload   (last_payload)
  );

  // ---------------------------------------------------------------------------
  // Parser mirror: markers, frame position and held header fields
  // ---------------------------------------------------------------------------
  logic [ByteW-1:0] mark_a   = FirstMarkerReset;
  logic [ByteW-1:0] mark_b   = SecondMarkerReset;
  mlfp_phase_t      ph_now   = PH_HUNT;
  logic [WordW-1:0] pay_left = '0;
  logic [WordW-1:0] len_word = '0;
  logic [ByteW-1:0] op_hold  = '0;
  logic [WordW-1:0] id_hold  = '0;

  // Parse results still owed by the block, oldest first.
  mlfp_result_t parse_results_q[$];
  // Bytes waiting to be offered on the input channel.
  logic [ByteW-1:0] tx_q[$];

  int in_idle_pct    = 0;
  int out_idle_pct   = 0;
  int sent_count     = 0;
  int mismatch_count = 0;
  int stall_cycles   = 0;

  // Append one byte to the outgoing stream.
  task automatic add_tx_byte(input logic [ByteW-1:0] b);
    tx_q.insert(tx_q.size(), b);
  endtask

  // Advance the mirror by one accepted byte; queue the result it yields, if any.
  task automatic parse_byte(input logic [ByteW-1:0] b);
    mlfp_result_t r;
    logic         emit;
    logic         with_frame;
    r          = '0;
    emit       = 1'b0;
    with_frame = 1'b0;
    case (ph_now)
      PH_MARK2: begin
        // a wrong second marker sends us back to hunting; the byte itself
        // is not retried as a first marker
        if (b == mark_b) begin
          ph_now = PH_LEN_HI;
        end else begin
          ph_now = PH_HUNT;
          r.kind = K_BAD_MARKER;
          emit   = 1'b1;
        end
      end
      PH_LEN_HI: begin
        len_word = {b, 8'h00};
        ph_now   = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_word = {len_word[WordW-1:ByteW], b};
        if (len_word < HdrOverhead) begin
          ph_now = PH_HUNT;
          r.kind = K_BAD_LENGTH;
          emit   = 1'b1;
        end else begin
          pay_left = len_word - HdrOverhead;
          ph_now   = PH_OP;
        end
      end
      PH_OP: begin
        op_hold = b;
        ph_now  = PH_ID_HI;
      end
      PH_ID_HI: begin
        id_hold = {b, 8'h00};
        ph_now  = PH_ID_LO;
      end
      PH_ID_LO: begin
        id_hold = {id_hold[WordW-1:ByteW], b};
        // empty payload skips straight to the trailer
        if (pay_left != '0) begin
          ph_now = PH_DATA;
        end else begin
          ph_now = PH_TRAIL1;
        end
        r.kind     = K_HEADER;
        emit       = 1'b1;
        with_frame = 1'b1;
      end
      PH_DATA: begin
        r.last_payload = (pay_left <= 16'd1);
        if (pay_left != '0) begin
          pay_left = pay_left - 16'd1;
        end
        if (pay_left == '0) begin
          ph_now = PH_TRAIL1;
        end
        r.kind      = K_PAYLOAD;
        r.data_byte = b;
        emit        = 1'b1;
        with_frame  = 1'b1;
      end
      PH_TRAIL1: begin
        ph_now = PH_TRAIL2;
      end
      PH_TRAIL2: begin
        ph_now     = PH_HUNT;
        r.kind     = K_DONE;
        emit       = 1'b1;
        with_frame = 1'b1;
      end
      default: begin
        // hunting: anything but the first marker is flagged
        if (b == mark_a) begin
          ph_now = PH_MARK2;
        end else begin
          ph_now = PH_HUNT;
          r.kind = K_BAD_MARKER;
          emit   = 1'b1;
        end
      end
    endcase
    if (with_frame) begin
      r.op_type        = op_hold;
      r.msg_id         = id_hold;
      r.payload_length = len_word - HdrOverhead;
    end
    if (emit) begin
      parse_results_q.insert(parse_results_q.size(), r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one byte, with random idle cycles first; valid stays up afterwards
  // so back-to-back requests keep it high without a glitch.
  task automatic send_byte(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (!in_ready);
    parse_byte(b);
    sent_count++;
  endtask

  task automatic send_queue();
    while (tx_q.size() != 0) begin
      send_byte(tx_q.pop_front());
    end
  endtask

  // Drop valid, wait for every owed result, then let the input register drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (parse_results_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Marker writes happen only on an idle block.
  task automatic set_marker(input logic idx, input logic [ByteW-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgFirstMarker) begin
      mark_a = value;
    end else begin
      mark_b = value;
    end
  endtask

  // Markers, length field, op, id, body_n body bytes, two trailer bytes.
  // body_n need not match the length field (broken frames).
  task automatic queue_frame(input logic [WordW-1:0] len, input logic [ByteW-1:0] op,
                             input logic [WordW-1:0] id, input int body_n);
    add_tx_byte(mark_a);
    add_tx_byte(mark_b);
    add_tx_byte(len[WordW-1:ByteW]);
    add_tx_byte(len[ByteW-1:0]);
    add_tx_byte(op);
    add_tx_byte(id[WordW-1:ByteW]);
    add_tx_byte(id[ByteW-1:0]);
    repeat (body_n) add_tx_byte(ByteW'($urandom));
    repeat (2) add_tx_byte(ByteW'($urandom));
  endtask

  // One random piece of stream: mostly good frames with random content,
  // the rest noise, bad second markers, short lengths and mis-sized frames.
  task automatic queue_random_chunk();
    int               pick;
    int               n;
    logic [ByteW-1:0] b;
    pick = $urandom_range(99);
    if (pick < 65) begin
      // a few longer frames, some with a length high byte above zero
      if ($urandom_range(19) == 0) begin
        n = $urandom_range(300, 13);
      end else begin
        n = $urandom_range(12, 0);
      end
      queue_frame(WordW'(n + 3), ByteW'($urandom), WordW'($urandom), n);
    end else if (pick < 73) begin
      repeat ($urandom_range(4, 1)) add_tx_byte(ByteW'($urandom));
    end else if (pick < 81) begin
      b = ByteW'($urandom);
      if (b == mark_b) begin
        b = ~b;
      end
      add_tx_byte(mark_a);
      add_tx_byte(b);
    end else if (pick < 89) begin
      add_tx_byte(mark_a);
      add_tx_byte(mark_b);
      add_tx_byte(8'h00);
      add_tx_byte(ByteW'($urandom_range(2)));
    end else begin
      // length and body disagree: the parser drifts through the next bytes
      n = $urandom_range(12, 0);
      queue_frame(WordW'(n + 3), ByteW'($urandom), WordW'($urandom),
                  $urandom_range(12, 0));
    end
  endtask

  task automatic run_traffic(input int in_pct, input int out_pct, input int items);
    int start_count;
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    start_count  = sent_count;
    while (sent_count - start_count < items) begin
      queue_random_chunk();
      send_queue();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: receiver stalls, result check, watchdog
  // ---------------------------------------------------------------------------
  task automatic report_result(input string what, input mlfp_result_t want,
                               input mlfp_result_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReports) begin
      $display("%0t %s: want kind=%0d op=%02h id=%04h len=%0d data=%02h last=%0b",
               $time, what, want.kind, want.op_type, want.msg_id, want.payload_length,
               want.data_byte, want.last_payload);
      $display("%0t %s:  got kind=%0d op=%02h id=%04h len=%0d data=%02h last=%0b",
               $time, what, got.kind, got.op_type, got.msg_id, got.payload_length,
               got.data_byte, got.last_payload);
    end
  endtask

  // Values read here are the ones held before this edge, so a request seen
  // here is the one the block takes at this edge.
  always @(posedge clk) begin : check_results
    mlfp_result_t want_r;
    mlfp_result_t got_r;
    if (!rst && out_valid && out_ready) begin
      got_r.kind           = mlfp_kind_t'(kind);
      got_r.op_type        = op_type;
      got_r.msg_id         = msg_id;
      got_r.payload_length = payload_length;
      got_r.data_byte      = data_byte;
      got_r.last_payload   = last_payload;
      if (parse_results_q.size() == 0) begin
        report_result("unexpected result", '0, got_r);
      end else begin
        want_r = parse_results_q.pop_front();
        if (got_r !== want_r) begin
          report_result("result mismatch", want_r, got_r);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Counts cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset markers; each special case once, plus field extremes.
  task automatic test_directed_cases();
    in_idle_pct  = 24;
    out_idle_pct = 60;
    tx_q = '{
      // empty payload, op and id all zero
      mark_a, mark_b, 8'h00, 8'h03, 8'h00, 8'h00, 8'h00, 8'h5A, 8'hA5,
      // stray byte while hunting
      8'h00,
      // wrong second marker; that byte is a first marker but is not retried
      mark_a, mark_a,
      // length below the header overhead
      mark_a, mark_b, 8'h00, 8'h02,
      // two payload bytes at the extremes, op and id all ones
      mark_a, mark_b, 8'h00, 8'h05, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'hFF
    };
    send_queue();
  endtask

  // Marker pairs at the extremes and equal to each other.
  task automatic test_marker_registers();
    logic [ByteW-1:0] pairs[3][2];
    pairs = '{'{8'h00, 8'hFF}, '{8'hFF, 8'h00}, '{8'h3C, 8'h3C}};
    for (int p = 0; p < 3; p++) begin
      set_marker(CfgFirstMarker, pairs[p][0]);
      set_marker(CfgSecondMarker, pairs[p][1]);
      queue_frame(16'd4, ByteW'($urandom), WordW'($urandom), 1);
      repeat (8) queue_random_chunk();
      send_queue();
    end
  endtask

  // Long random stream under three idling patterns, new markers for each.
  task automatic test_random_traffic();
    int pct[3][2];
    pct = '{'{24, 60}, '{60, 24}, '{0, 0}};
    for (int p = 0; p < 3; p++) begin
      set_marker(CfgFirstMarker, ByteW'($urandom));
      set_marker(CfgSecondMarker, ByteW'($urandom));
      run_traffic(pct[p][0], pct[p][1], 240);
    end
  endtask

  // Largest length field: header and the first payload bytes, with the
  // payload counter starting from its largest value, 0xFFFC. The frame is left open.
  task automatic test_longest_frame();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    set_marker(CfgFirstMarker, FirstMarkerReset);
    set_marker(CfgSecondMarker, SecondMarkerReset);
    queue_frame(16'hFFFF, ByteW'($urandom), WordW'($urandom), 62);
    send_queue();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_marker_registers();
    test_random_traffic();
    test_longest_frame();
    settle();
    if (mismatch_count == 0 && parse_results_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
